FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/lmdt_pkg.sv
`timescale 1ns / 1ps

package lmdt_pkg;

    localparam int WT_W       = 20;
    localparam int DIST_W     = 24;
    localparam int MOM_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int CEIL_W     = 23;
    localparam int QTHR_W     = 48;
    localparam int THR_W      = 16;
    localparam int QLVL_W     = 2;
    localparam int MAX_LEVELS = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam int GAIN_FRAC  = 14;
    localparam int PROD_W     = MOM_W + GAIN_W;
    localparam int RND_W      = PROD_W - GAIN_FRAC;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_FRAC - 1);

    localparam int HISTORY_DEPTH_DEF  = 10;
    localparam int QUALITY_LEVELS_DEF = 3;

    localparam logic        [WT_W-1:0]   TARGET_RST  = WT_W'(16333);
    localparam logic        [DIST_W-1:0] DMIN_RST    = DIST_W'(640000);
    localparam logic        [DIST_W-1:0] DMAX_RST    = DIST_W'(3072000);
    localparam logic        [GAIN_W-1:0] GAIN_UP_RST = GAIN_W'(16794);
    localparam logic        [GAIN_W-1:0] GAIN_DN_RST = GAIN_W'(18022);
    localparam logic signed [MOM_W-1:0]  FLOOR_RST   = -MOM_W'(256000);
    localparam logic        [CEIL_W-1:0] CEIL_RST    = CEIL_W'(128000);
    localparam logic        [QTHR_W-1:0] QTHR_RST    = QTHR_W'(10000);

    // Momentum values in Q16.8.
    localparam logic signed [MOM_W-1:0] MOM_PLUS_ONE  = MOM_W'(256);
    localparam logic signed [MOM_W-1:0] MOM_MINUS_TWO = -MOM_W'(512);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_WORK_TIME  = 3'd0,
        CFG_DISTANCE_MIN      = 3'd1,
        CFG_DISTANCE_MAX      = 3'd2,
        CFG_GAIN_UP           = 3'd3,
        CFG_GAIN_DOWN         = 3'd4,
        CFG_MOMENTUM_FLOOR    = 3'd5,
        CFG_MOMENTUM_CEILING  = 3'd6,
        CFG_QUALITY_THRESHOLD = 3'd7
    } cfg_reg_t;

    // Control from the pipeline to the history ring.
    typedef struct packed {
        logic push;    // a frame transfer writes the ring
        logic retire;  // the first stage hands its item on
    } ring_ctrl_t;

endpackage

FILE: rtl/lmdt_if.sv
`timescale 1ns / 1ps

interface lmdt_frame_if;
    logic                       valid;
    logic                       ready;
    logic [lmdt_pkg::WT_W-1:0]   work_time;
    logic [lmdt_pkg::DIST_W-1:0] current_distance;
    logic                       in_menu;
    logic                       is_paused;
    logic                       is_loading;

    modport source (output valid, work_time, current_distance, in_menu, is_paused,
                    is_loading, input ready);
    modport sink (input valid, work_time, current_distance, in_menu, is_paused,
                  is_loading, output ready);
endinterface

interface lmdt_result_if;
    logic                              valid;
    logic                              ready;
    logic [lmdt_pkg::DIST_W-1:0]        new_distance;
    logic [lmdt_pkg::QLVL_W-1:0]        quality_level;
    logic                              adjusted;
    logic signed [lmdt_pkg::MOM_W-1:0]  momentum_out;

    modport source (output valid, new_distance, quality_level, adjusted, momentum_out,
                    input ready);
    modport sink (input valid, new_distance, quality_level, adjusted, momentum_out,
                  output ready);
endinterface

interface lmdt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lmdt_pkg::CFG_IDX_W-1:0]   index;
    logic [lmdt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/lmdt_ring.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmdt_ring #(
    parameter int HISTORY_DEPTH = lmdt_pkg::HISTORY_DEPTH_DEF,
    parameter int CNT_W         = $clog2(HISTORY_DEPTH + 1),
    parameter int SUM_W         = lmdt_pkg::WT_W + CNT_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lmdt_pkg::ring_ctrl_t      ctrl,
    input  logic [lmdt_pkg::WT_W-1:0] wt,
    output logic [SUM_W-1:0]          sum_next,
    output logic [CNT_W-1:0]          count_s1
);
    import lmdt_pkg::*;

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HISTORY_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

    logic [WT_W-1:0]  mem [HISTORY_DEPTH];
    logic [WT_W-1:0]  rd_data_reg;
    logic [WT_W-1:0]  wt_s1_reg;
    logic             full_s1_reg;
    logic [CNT_W-1:0] count_s1_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [SUM_W-1:0] sum_reg;
    logic             full;

    // Read-first port: the entry about to be overwritten is registered in
    // rd_data_reg as the new value is written. Consecutive pushes go to
    // different entries, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            rd_data_reg  <= mem[idx_reg];
            mem[idx_reg] <= wt;
        end
    end

    assign full       = (count_reg == FULL_CNT);
    assign idx_next   = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
    assign count_next = full ? count_reg : count_reg + CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            wt_s1_reg    <= wt;
            full_s1_reg  <= full;
            count_s1_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                idx_reg   <= idx_next;
                count_reg <= count_next;
            end
            if (ctrl.retire)
                sum_reg <= sum_next;
        end
    end

    assign sum_next = sum_reg - (full_s1_reg ? SUM_W'(rd_data_reg) : '0) + SUM_W'(wt_s1_reg);
    assign count_s1 = count_s1_reg;

    // While the ring fills, the write pointer tracks the fill count.
    `ASSERT_IMPL(a_idx_tracks_count, count_reg != FULL_CNT, count_reg == CNT_W'(idx_reg))
    `ASSERT_NEXT(a_full_sticky, count_reg == FULL_CNT, count_reg == FULL_CNT)

endmodule

FILE: rtl/load_momentum_distance_tuner_core.sv
// A frame passes stages 1 to 4, then the output register. Throughput: one
// frame per cycle unless the result side stalls; the momentum loop (one
// 24x16 multiply, rounding and limit per cycle) and the one-port history
// ring set this rate. Reset: momentum +1.0, empty history, config registers
// at defaults; the ring is not cleared: entries are read only after a write.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module load_momentum_distance_tuner_core #(
    parameter int HISTORY_DEPTH  = lmdt_pkg::HISTORY_DEPTH_DEF,
    parameter int QUALITY_LEVELS = lmdt_pkg::QUALITY_LEVELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lmdt_frame_if.sink    frame,
    lmdt_result_if.source result,
    lmdt_cfg_if.sink      cfg
);
    import lmdt_pkg::*;

    localparam int CNT_W    = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W    = WT_W + CNT_W;
    localparam int QUAL_LIM = (QUALITY_LEVELS < MAX_LEVELS) ? QUALITY_LEVELS : MAX_LEVELS;

    // Configuration registers
    logic        [WT_W-1:0]   target_reg;
    logic        [DIST_W-1:0] dmin_reg;
    logic        [DIST_W-1:0] dmax_reg;
    logic        [GAIN_W-1:0] gain_up_reg;
    logic        [GAIN_W-1:0] gain_dn_reg;
    logic signed [MOM_W-1:0]  floor_reg;
    logic        [CEIL_W-1:0] ceil_reg;
    logic        [QTHR_W-1:0] qthr_reg;

    logic signed [MOM_W-1:0]  momentum_reg;
    logic signed [MOM_W-1:0]  momentum_next;

    logic advance;
    logic accept;
    ring_ctrl_t ring_ctrl;

    // Stage 1: ring read data arrives
    logic              v1_reg;
    logic [DIST_W-1:0] cur_s1_reg;
    logic              hold_s1_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  count_s1;

    // Stage 2: running sum and target product
    logic              v2_reg;
    logic [SUM_W-1:0]  sum_s2_reg;
    logic [SUM_W-1:0]  thr_s2_reg;
    logic [DIST_W-1:0] cur_s2_reg;
    logic              hold_s2_reg;

    // Stage 3: momentum update
    logic              v3_reg;
    logic              below_s3_reg;
    logic [DIST_W-1:0] cur_s3_reg;
    logic              hold_s3_reg;

    // Stage 4: distance and quality
    logic                    v4_reg;
    logic [DIST_W-1:0]       cur_s4_reg;
    logic                    hold_s4_reg;
    logic signed [MOM_W-1:0] mom_s4_reg;

    // Output register
    logic                    out_valid_reg;
    logic [DIST_W-1:0]       nd_out_reg;
    logic [QLVL_W-1:0]       q_out_reg;
    logic                    adj_out_reg;
    logic signed [MOM_W-1:0] mom_out_reg;

    assign advance     = !out_valid_reg || result.ready;
    assign accept      = frame.valid && advance;
    assign frame.ready = advance;
    assign cfg.ready   = 1'b1;

    assign ring_ctrl.push   = accept;
    assign ring_ctrl.retire = v1_reg && advance;

    lmdt_ring #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CNT_W         (CNT_W),
        .SUM_W         (SUM_W)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ring_ctrl),
        .wt       (frame.work_time),
        .sum_next (sum_next),
        .count_s1 (count_s1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= TARGET_RST;
            dmin_reg    <= DMIN_RST;
            dmax_reg    <= DMAX_RST;
            gain_up_reg <= GAIN_UP_RST;
            gain_dn_reg <= GAIN_DN_RST;
            floor_reg   <= FLOOR_RST;
            ceil_reg    <= CEIL_RST;
            qthr_reg    <= QTHR_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                CFG_TARGET_WORK_TIME:  target_reg  <= cfg.data[WT_W-1:0];
                CFG_DISTANCE_MIN:      dmin_reg    <= cfg.data[DIST_W-1:0];
                CFG_DISTANCE_MAX:      dmax_reg    <= cfg.data[DIST_W-1:0];
                CFG_GAIN_UP:           gain_up_reg <= cfg.data[GAIN_W-1:0];
                CFG_GAIN_DOWN:         gain_dn_reg <= cfg.data[GAIN_W-1:0];
                CFG_MOMENTUM_FLOOR:    floor_reg   <= $signed(cfg.data[MOM_W-1:0]);
                CFG_MOMENTUM_CEILING:  ceil_reg    <= cfg.data[CEIL_W-1:0];
                CFG_QUALITY_THRESHOLD: qthr_reg    <= cfg.data[QTHR_W-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits of the pipeline and the momentum register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            momentum_reg  <= MOM_PLUS_ONE;
        end
        else if (advance)
        begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
            if (v3_reg && !hold_s3_reg)
                momentum_reg <= momentum_next;
        end
    end

    // Momentum step: reversal resets, otherwise scale the magnitude by the
    // selected gain, round half away from zero and limit.
    logic [MOM_W-1:0]        mag_s3;
    logic [GAIN_W-1:0]       gain_s3;
    logic [PROD_W-1:0]       prod_s3;
    logic [RND_W-1:0]        rnd_s3;
    logic signed [RND_W:0]   neg_s3;

    always_comb
    begin
        mag_s3  = momentum_reg[MOM_W-1] ? (~momentum_reg + MOM_W'(1)) : momentum_reg;
        gain_s3 = below_s3_reg ? gain_up_reg : gain_dn_reg;
        prod_s3 = PROD_W'(mag_s3) * PROD_W'(gain_s3) + ROUND_HALF;
        rnd_s3  = prod_s3[PROD_W-1:GAIN_FRAC];
        neg_s3  = -$signed({1'b0, rnd_s3});
        if (below_s3_reg)
        begin
            if (momentum_reg[MOM_W-1])
                momentum_next = MOM_PLUS_ONE;
            else if (rnd_s3 > RND_W'(ceil_reg))
                momentum_next = MOM_W'(ceil_reg);
            else
                momentum_next = rnd_s3[MOM_W-1:0];
        end
        else
        begin
            if (!momentum_reg[MOM_W-1] && (momentum_reg != '0))
                momentum_next = MOM_MINUS_TWO;
            else if (neg_s3 < (RND_W+1)'(floor_reg))
                momentum_next = floor_reg;
            else
                momentum_next = neg_s3[MOM_W-1:0];
        end
    end

    // Distance limit and quality level.
    logic signed [DIST_W+1:0] dsum_s4;
    logic signed [DIST_W+1:0] dlim_s4;
    logic [DIST_W-1:0]        nd_s4;
    logic [THR_W-1:0]         ip_s4;
    logic [QLVL_W-1:0]        q_s4;

    always_comb
    begin
        dsum_s4 = $signed({2'b00, cur_s4_reg}) + (DIST_W+2)'(mom_s4_reg);
        dlim_s4 = dsum_s4;
        if (dlim_s4 > $signed({2'b00, dmax_reg}))
            dlim_s4 = $signed({2'b00, dmax_reg});
        if (dlim_s4 < $signed({2'b00, dmin_reg}))
            dlim_s4 = $signed({2'b00, dmin_reg});
        nd_s4 = hold_s4_reg ? cur_s4_reg : dlim_s4[DIST_W-1:0];
        ip_s4 = nd_s4[DIST_W-1:DIST_W-THR_W];
        q_s4  = QLVL_W'(QUAL_LIM);
        for (int i = QUAL_LIM - 1; i >= 0; i--)
        begin
            if (ip_s4 < qthr_reg[i*THR_W +: THR_W])
                q_s4 = QLVL_W'(i);
        end
    end

    // Stage payloads carry no reset.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (accept)
            begin
                cur_s1_reg  <= frame.current_distance;
                hold_s1_reg <= frame.in_menu || frame.is_paused || frame.is_loading;
            end
            sum_s2_reg   <= sum_next;
            thr_s2_reg   <= SUM_W'(target_reg) * SUM_W'(count_s1);
            cur_s2_reg   <= cur_s1_reg;
            hold_s2_reg  <= hold_s1_reg;
            below_s3_reg <= (sum_s2_reg < thr_s2_reg);
            cur_s3_reg   <= cur_s2_reg;
            hold_s3_reg  <= hold_s2_reg;
            cur_s4_reg   <= cur_s3_reg;
            hold_s4_reg  <= hold_s3_reg;
            mom_s4_reg   <= hold_s3_reg ? momentum_reg : momentum_next;
            if (v4_reg)
            begin
                nd_out_reg  <= nd_s4;
                q_out_reg   <= q_s4;
                adj_out_reg <= !hold_s4_reg;
                mom_out_reg <= mom_s4_reg;
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.new_distance  = nd_out_reg;
    assign result.quality_level = q_out_reg;
    assign result.adjusted      = adj_out_reg;
    assign result.momentum_out  = mom_out_reg;

    // Under target the momentum can only end up non-negative.
    `ASSERT_NEXT(a_under_nonneg, advance && v3_reg && !hold_s3_reg && below_s3_reg,
                 !momentum_reg[MOM_W-1])
    // A held frame leaves the momentum alone.
    `ASSERT_NEXT(a_hold_keeps_mom, advance && v3_reg && hold_s3_reg, $stable(momentum_reg))
    // With sane limits an adjusted distance lies between them.
    `ASSERT_IMPL(a_dist_in_limits, out_valid_reg && adj_out_reg && (dmin_reg <= dmax_reg),
                 (nd_out_reg >= dmin_reg) && (nd_out_reg <= dmax_reg))

endmodule
